// File: rtl/revolute_joint_angle_from_target_assert.svh
// Assertion macros shared by the joint angle solver checkers.
`ifndef REVOLUTE_JOINT_ANGLE_FROM_TARGET_ASSERT_SVH
`define REVOLUTE_JOINT_ANGLE_FROM_TARGET_ASSERT_SVH

// Same-cycle implication.
`define RJAFT_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("joint angle solver: same-cycle check failed");

// Next-cycle implication.
`define RJAFT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("joint angle solver: next-cycle check failed");

`endif

// File: rtl/rjaft_pkg.sv
// Shared types, constants and helper functions of the joint angle solver.
package rjaft_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int FRONT_STAGES  = 10;
   localparam int POST_STAGES   = 3;
   localparam int PIPE_STAGES   = FRONT_STAGES + CORDIC_STAGES + POST_STAGES;

   localparam logic signed [15:0] PI_Q12      = 16'sd12868;
   localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;

   typedef enum logic [2:0] {
      CSR_AXIS,
      CSR_REFERENCE,
      CSR_ORIGIN_X,
      CSR_ORIGIN_Y,
      CSR_ORIGIN_Z,
      CSR_LOWER_LIMIT,
      CSR_UPPER_LIMIT,
      CSR_THRESHOLD
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_SUCCESS,
      ST_SINGULAR,
      ST_UNREACHABLE
   } status_type;

   typedef struct packed {
      logic [47:0]        axis;
      logic [47:0]        refd;
      logic signed [23:0] origin_x;
      logic signed [23:0] origin_y;
      logic signed [23:0] origin_z;
      logic signed [15:0] lower;
      logic signed [15:0] upper;
      logic [15:0]        thr;
   } cfg_type;

   typedef struct packed {
      logic signed [15:0] seed;
      logic               sing;
      logic               szero;
      logic               cneg;
   } side_type;

   typedef struct packed {
      logic signed [49:0] x;
      logic signed [49:0] y;
      logic signed [19:0] z;
      side_type           side;
   } cord_type;

   // One signed Q1.14 component of a packed direction vector.
   function automatic logic signed [15:0] comp(input logic [47:0] packed_vec,
                                               input logic [1:0] k);
      logic signed [15:0] v;
      case (k)
         2'd0:    v = signed'(packed_vec[15:0]);
         2'd1:    v = signed'(packed_vec[31:16]);
         2'd2:    v = signed'(packed_vec[47:32]);
         default: v = '0;
      endcase
      return v;
   endfunction

   // Rounded atan(2^-i) in Q16 radians.
   function automatic logic [15:0] atan_q16(input logic [4:0] idx);
      logic [15:0] v;
      case (idx)
         5'd0:    v = 16'd51472;
         5'd1:    v = 16'd30386;
         5'd2:    v = 16'd16055;
         5'd3:    v = 16'd8150;
         5'd4:    v = 16'd4091;
         5'd5:    v = 16'd2047;
         5'd6:    v = 16'd1024;
         5'd7:    v = 16'd512;
         5'd8:    v = 16'd256;
         5'd9:    v = 16'd128;
         5'd10:   v = 16'd64;
         5'd11:   v = 16'd32;
         5'd12:   v = 16'd16;
         5'd13:   v = 16'd8;
         5'd14:   v = 16'd4;
         5'd15:   v = 16'd2;
         5'd16:   v = 16'd1;
         default: v = 16'd0;
      endcase
      return v;
   endfunction

   function automatic logic in_range(input logic signed [15:0] th,
                                     input logic signed [15:0] lo,
                                     input logic signed [15:0] hi);
      return (th >= lo) && (th <= hi);
   endfunction

   // Keeps a unless b is strictly closer to the seed.
   function automatic logic signed [15:0] closer(input logic signed [15:0] seed,
                                                 input logic signed [15:0] a,
                                                 input logic signed [15:0] b);
      logic signed [16:0] da;
      logic signed [16:0] db;
      logic [16:0]        ma;
      logic [16:0]        mb;
      da = 17'(a) - 17'(seed);
      db = 17'(b) - 17'(seed);
      ma = da[16] ? 17'(-da) : 17'(da);
      mb = db[16] ? 17'(-db) : 17'(db);
      return (mb < ma) ? b : a;
   endfunction

endpackage

// File: rtl/revolute_joint_angle_from_target.sv
// Throughput: one word per cycle while the response side is ready; the
// 16 CORDIC cells and the projection multipliers are fully pipelined,
// and bubbles close up when the response side stalls. Reset clears every
// pipeline valid bit and returns the configuration registers to their
// defaults; no clearing pass is needed.
module revolute_joint_angle_from_target (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [23:0] req_target_x,
   input  logic signed [23:0] req_target_y,
   input  logic signed [23:0] req_target_z,
   input  logic signed [15:0] req_seed_angle,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_joint_angle,
   output logic [1:0]         rsp_solve_status,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [47:0]        csr_write_data
);

   localparam int NSTG = rjaft_pkg::PIPE_STAGES;
   localparam int CSTG = rjaft_pkg::CORDIC_STAGES;
   localparam int FSTG = rjaft_pkg::FRONT_STAGES;

   rjaft_pkg::cfg_type    cfg_ff;
   logic [NSTG:0]         load;
   logic [NSTG-1:0]       vld_in, vld_ff;
   rjaft_pkg::cord_type   cell_d [CSTG+1];
   rjaft_pkg::status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.axis     <= '0;
         cfg_ff.refd     <= '0;
         cfg_ff.origin_x <= '0;
         cfg_ff.origin_y <= '0;
         cfg_ff.origin_z <= '0;
         cfg_ff.lower    <= -rjaft_pkg::PI_Q12;
         cfg_ff.upper    <= rjaft_pkg::PI_Q12;
         cfg_ff.thr      <= 16'd1;
      end else if (csr_write_en) begin
         unique case (rjaft_pkg::csr_index_type'(csr_index))
            rjaft_pkg::CSR_AXIS:        cfg_ff.axis     <= csr_write_data;
            rjaft_pkg::CSR_REFERENCE:   cfg_ff.refd     <= csr_write_data;
            rjaft_pkg::CSR_ORIGIN_X:    cfg_ff.origin_x <= signed'(csr_write_data[23:0]);
            rjaft_pkg::CSR_ORIGIN_Y:    cfg_ff.origin_y <= signed'(csr_write_data[23:0]);
            rjaft_pkg::CSR_ORIGIN_Z:    cfg_ff.origin_z <= signed'(csr_write_data[23:0]);
            rjaft_pkg::CSR_LOWER_LIMIT: cfg_ff.lower    <= signed'(csr_write_data[15:0]);
            rjaft_pkg::CSR_UPPER_LIMIT: cfg_ff.upper    <= signed'(csr_write_data[15:0]);
            rjaft_pkg::CSR_THRESHOLD:   cfg_ff.thr      <= csr_write_data[15:0];
            default: ;
         endcase
      end
   end

   // A stage loads when it is empty or its word moves on.
   always_comb begin
      load[NSTG] = rsp_ready;
      for (int i = NSTG - 1; i >= 0; i--) begin
         load[i] = !vld_ff[i] || load[i+1];
      end
      vld_in[0] = req_valid;
      for (int i = 1; i < NSTG; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NSTG; i++) begin
            if (load[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   rjaft_front u_front (
      .clock      (clock),
      .en         (load[FSTG-1:0]),
      .cfg        (cfg_ff),
      .target_x   (req_target_x),
      .target_y   (req_target_y),
      .target_z   (req_target_z),
      .seed_angle (req_seed_angle),
      .dout       (cell_d[0])
   );

   for (genvar g = 0; g < CSTG; g++) begin : g_cell
      rjaft_cordic_cell u_cell (
         .clock     (clock),
         .en        (load[FSTG+g]),
         .stage_idx (5'(g)),
         .din       (cell_d[g]),
         .dout      (cell_d[g+1])
      );
   end

   rjaft_select u_select (
      .clock        (clock),
      .en           (load[NSTG-1:FSTG+CSTG]),
      .din          (cell_d[CSTG]),
      .lower        (cfg_ff.lower),
      .upper        (cfg_ff.upper),
      .joint_angle  (rsp_joint_angle),
      .solve_status (status)
   );

   assign req_ready        = load[0];
   assign rsp_valid        = vld_ff[NSTG-1];
   assign rsp_solve_status = status;

endmodule

// File: rtl/rjaft_front.sv
// Projection onto the joint plane, singularity test and CORDIC pre-rotation.
module rjaft_front (
   input  logic                                clock,
   input  logic [rjaft_pkg::FRONT_STAGES-1:0] en,
   input  rjaft_pkg::cfg_type                  cfg,
   input  logic signed [23:0]                  target_x,
   input  logic signed [23:0]                  target_y,
   input  logic signed [23:0]                  target_z,
   input  logic signed [15:0]                  seed_angle,
   output rjaft_pkg::cord_type                 dout
);

   logic signed [15:0] ax [3];
   logic signed [15:0] rd [3];

   logic signed [24:0] r0_in [3], r0_ff [3], r1_ff [3], r2_ff [3], r3_ff [3];
   logic signed [40:0] prod1_in [3], prod1_ff [3];
   logic signed [42:0] d2_in, d2_ff;
   logic signed [58:0] da3_in [3], da3_ff [3];
   logic signed [59:0] p [3];
   logic signed [39:0] q4_in [3], q4_ff [3];
   logic [39:0]        qa [3];
   logic signed [24:0] qt [3];
   logic [23:0]        thr24;
   logic               lt5_in, lt5_ff;
   logic [49:0]        sq5_in [3], sq5_ff [3];
   logic [47:0]        thrsq5_in, thrsq5_ff;
   logic signed [55:0] cr5_in [6], cr5_ff [6];
   logic signed [55:0] dot5_in [3], dot5_ff [3];
   logic [49:0]        sqsum;
   logic               sing6_in, sing6_ff, sing7_ff, sing8_ff;
   logic signed [42:0] k6_in [3], k6_ff [3];
   logic signed [43:0] c6_in, c6_ff, c7_ff, c8_ff;
   logic signed [58:0] ak7_in [3], ak7_ff [3];
   logic signed [46:0] s8_in, s8_ff;
   logic signed [49:0] xc, ys;
   logic signed [15:0] seed0_ff, seed1_ff, seed2_ff, seed3_ff, seed4_ff;
   logic signed [15:0] seed5_ff, seed6_ff, seed7_ff, seed8_ff;
   rjaft_pkg::cord_type dout_in, dout_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ax[i] = rjaft_pkg::comp(cfg.axis, 2'(i));
         rd[i] = rjaft_pkg::comp(cfg.refd, 2'(i));
      end
      r0_in[0] = 25'(target_x) - 25'(cfg.origin_x);
      r0_in[1] = 25'(target_y) - 25'(cfg.origin_y);
      r0_in[2] = 25'(target_z) - 25'(cfg.origin_z);
      for (int i = 0; i < 3; i++) begin
         prod1_in[i] = 41'(r0_ff[i]) * 41'(ax[i]);
      end
      d2_in = 43'(prod1_ff[0]) + 43'(prod1_ff[1]) + 43'(prod1_ff[2]);
      for (int i = 0; i < 3; i++) begin
         da3_in[i] = 59'(d2_ff) * 59'(ax[i]);
         // Projected component in position units times 2^8, rounded half up.
         p[i] = (60'(r3_ff[i]) <<< 28) - 60'(da3_ff[i]);
         q4_in[i] = 40'((p[i] + 60'sd524288) >>> 20);
      end
      thr24 = {cfg.thr, 8'd0};
      lt5_in = 1'b1;
      for (int i = 0; i < 3; i++) begin
         qa[i] = q4_ff[i][39] ? 40'(-q4_ff[i]) : 40'(q4_ff[i]);
         lt5_in = lt5_in && (qa[i] < 40'(thr24));
         // The square only matters when the magnitude already fits below 2^24.
         qt[i] = signed'(q4_ff[i][24:0]);
         sq5_in[i] = 50'(50'(qt[i]) * 50'(qt[i]));
         dot5_in[i] = 56'(rd[i]) * 56'(q4_ff[i]);
      end
      thrsq5_in = 48'(thr24) * 48'(thr24);
      cr5_in[0] = 56'(rd[1]) * 56'(q4_ff[2]);
      cr5_in[1] = 56'(rd[2]) * 56'(q4_ff[1]);
      cr5_in[2] = 56'(rd[2]) * 56'(q4_ff[0]);
      cr5_in[3] = 56'(rd[0]) * 56'(q4_ff[2]);
      cr5_in[4] = 56'(rd[0]) * 56'(q4_ff[1]);
      cr5_in[5] = 56'(rd[1]) * 56'(q4_ff[0]);
      sqsum = sq5_ff[0] + sq5_ff[1] + sq5_ff[2];
      sing6_in = lt5_ff && (sqsum < 50'(thrsq5_ff));
      for (int i = 0; i < 3; i++) begin
         k6_in[i] = 43'((57'(cr5_ff[2*i]) - 57'(cr5_ff[2*i+1]) + 57'sd8192) >>> 14);
         ak7_in[i] = 59'(ax[i]) * 59'(k6_ff[i]);
      end
      c6_in = 44'((58'(dot5_ff[0]) + 58'(dot5_ff[1]) + 58'(dot5_ff[2])
                   + 58'sd8192) >>> 14);
      s8_in = 47'((61'(ak7_ff[0]) + 61'(ak7_ff[1]) + 61'(ak7_ff[2])
                   + 61'sd8192) >>> 14);

      // Fold the left half plane into the right one by a quarter turn.
      xc = 50'(c8_ff);
      ys = 50'(s8_ff);
      dout_in.side.seed  = seed8_ff;
      dout_in.side.sing  = sing8_ff;
      dout_in.side.szero = (s8_ff == 47'sd0);
      dout_in.side.cneg  = c8_ff[43];
      if (c8_ff[43]) begin
         if (!s8_ff[46]) begin
            dout_in.x = ys;
            dout_in.y = -xc;
            dout_in.z = rjaft_pkg::HALF_PI_Q16;
         end else begin
            dout_in.x = -ys;
            dout_in.y = xc;
            dout_in.z = -rjaft_pkg::HALF_PI_Q16;
         end
      end else begin
         dout_in.x = xc;
         dout_in.y = ys;
         dout_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         r0_ff    <= r0_in;
         seed0_ff <= seed_angle;
      end
      if (en[1]) begin
         r1_ff    <= r0_ff;
         prod1_ff <= prod1_in;
         seed1_ff <= seed0_ff;
      end
      if (en[2]) begin
         r2_ff    <= r1_ff;
         d2_ff    <= d2_in;
         seed2_ff <= seed1_ff;
      end
      if (en[3]) begin
         r3_ff    <= r2_ff;
         da3_ff   <= da3_in;
         seed3_ff <= seed2_ff;
      end
      if (en[4]) begin
         q4_ff    <= q4_in;
         seed4_ff <= seed3_ff;
      end
      if (en[5]) begin
         lt5_ff    <= lt5_in;
         sq5_ff    <= sq5_in;
         thrsq5_ff <= thrsq5_in;
         cr5_ff    <= cr5_in;
         dot5_ff   <= dot5_in;
         seed5_ff  <= seed4_ff;
      end
      if (en[6]) begin
         sing6_ff <= sing6_in;
         k6_ff    <= k6_in;
         c6_ff    <= c6_in;
         seed6_ff <= seed5_ff;
      end
      if (en[7]) begin
         sing7_ff <= sing6_ff;
         c7_ff    <= c6_ff;
         ak7_ff   <= ak7_in;
         seed7_ff <= seed6_ff;
      end
      if (en[8]) begin
         sing8_ff <= sing7_ff;
         c8_ff    <= c7_ff;
         s8_ff    <= s8_in;
         seed8_ff <= seed7_ff;
      end
      if (en[9]) begin
         dout_ff <= dout_in;
      end
   end

   assign dout = dout_ff;

endmodule

// File: rtl/rjaft_cordic_cell.sv
// One vectoring CORDIC iteration with its own pipeline register.
module rjaft_cordic_cell (
   input  logic                clock,
   input  logic                en,
   input  logic [4:0]          stage_idx,
   input  rjaft_pkg::cord_type din,
   output rjaft_pkg::cord_type dout
);

   logic signed [49:0] x, y, xs, ys;
   logic signed [19:0] at;
   rjaft_pkg::cord_type dout_in, dout_ff;

   always_comb begin
      x  = din.x;
      y  = din.y;
      xs = x >>> stage_idx;
      ys = y >>> stage_idx;
      at = signed'(20'(rjaft_pkg::atan_q16(stage_idx)));
      dout_in = din;
      if (!y[49]) begin
         dout_in.x = x + ys;
         dout_in.y = y - xs;
         dout_in.z = din.z + at;
      end else begin
         dout_in.x = x - ys;
         dout_in.y = y + xs;
         dout_in.z = din.z - at;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dout_ff <= dout_in;
      end
   end

   assign dout = dout_ff;

endmodule

// File: rtl/rjaft_select.sv
// Angle rounding, second candidate, limit checks and final choice.
module rjaft_select (
   input  logic                               clock,
   input  logic [rjaft_pkg::POST_STAGES-1:0] en,
   input  rjaft_pkg::cord_type                din,
   input  logic signed [15:0]                 lower,
   input  logic signed [15:0]                 upper,
   output logic signed [15:0]                 joint_angle,
   output rjaft_pkg::status_type              solve_status
);

   logic signed [19:0] t;
   logic signed [15:0] th1_in, th1_ff, th1b_ff;
   logic signed [15:0] th2_in, th2_ff;
   logic               v1_in, v1_ff, v2_in, v2_ff, special;
   logic signed [15:0] seed0_ff, seed1_ff;
   logic               sing0_ff, sing1_ff;
   logic signed [15:0] ang_in, ang_ff;
   rjaft_pkg::status_type st_in, st_ff;

   always_comb begin
      t = (din.z + 20'sd8) >>> 4;
      if (din.side.szero) begin
         th1_in = din.side.cneg ? rjaft_pkg::PI_Q12 : 16'sd0;
      end else if (t > 20'(rjaft_pkg::PI_Q12)) begin
         th1_in = rjaft_pkg::PI_Q12;
      end else if (t < -20'(rjaft_pkg::PI_Q12)) begin
         th1_in = -rjaft_pkg::PI_Q12;
      end else begin
         th1_in = 16'(t);
      end

      // Angles on the zero/pi line take the second candidate from a fixed set.
      special = (th1_ff == 16'sd0) || (th1_ff == rjaft_pkg::PI_Q12)
                || (th1_ff == -rjaft_pkg::PI_Q12);
      v1_in = rjaft_pkg::in_range(th1_ff, lower, upper);
      th2_in = '0;
      v2_in = 1'b0;
      if (special) begin
         if (rjaft_pkg::in_range(16'sd0, lower, upper)) begin
            th2_in = '0;
            v2_in = 1'b1;
         end
         if (rjaft_pkg::in_range(rjaft_pkg::PI_Q12, lower, upper)) begin
            th2_in = v2_in ? rjaft_pkg::closer(seed0_ff, th2_in, rjaft_pkg::PI_Q12)
                           : rjaft_pkg::PI_Q12;
            v2_in = 1'b1;
         end
         if (rjaft_pkg::in_range(-rjaft_pkg::PI_Q12, lower, upper)) begin
            th2_in = v2_in ? rjaft_pkg::closer(seed0_ff, th2_in, -rjaft_pkg::PI_Q12)
                           : -rjaft_pkg::PI_Q12;
            v2_in = 1'b1;
         end
      end else begin
         th2_in = (th1_ff > 16'sd0) ? th1_ff - rjaft_pkg::PI_Q12
                                    : th1_ff + rjaft_pkg::PI_Q12;
         v2_in = rjaft_pkg::in_range(th2_in, lower, upper);
      end

      if (sing1_ff) begin
         ang_in = seed1_ff;
         st_in  = rjaft_pkg::ST_SINGULAR;
      end else if (v1_ff && v2_ff) begin
         ang_in = rjaft_pkg::closer(seed1_ff, th1b_ff, th2_ff);
         st_in  = rjaft_pkg::ST_SUCCESS;
      end else if (v1_ff) begin
         ang_in = th1b_ff;
         st_in  = rjaft_pkg::ST_SUCCESS;
      end else if (v2_ff) begin
         ang_in = th2_ff;
         st_in  = rjaft_pkg::ST_SUCCESS;
      end else begin
         ang_in = seed1_ff;
         st_in  = rjaft_pkg::ST_UNREACHABLE;
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         th1_ff   <= th1_in;
         seed0_ff <= din.side.seed;
         sing0_ff <= din.side.sing;
      end
      if (en[1]) begin
         th1b_ff  <= th1_ff;
         th2_ff   <= th2_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         seed1_ff <= seed0_ff;
         sing1_ff <= sing0_ff;
      end
      if (en[2]) begin
         ang_ff <= ang_in;
         st_ff  <= st_in;
      end
   end

   assign joint_angle  = ang_ff;
   assign solve_status = st_ff;

endmodule

// File: rtl/rjaft_check.sv
// Port-level checks of the joint angle solver, bound to the top level.
`include "revolute_joint_angle_from_target_assert.svh"

module rjaft_check (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_joint_angle,
   input logic [1:0]         rsp_solve_status
);

   // A stalled response word must hold.
   `RJAFT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_joint_angle) && $stable(rsp_solve_status))

   // No status code beyond unreachable is ever produced.
   `RJAFT_ASSERT_IMPLY(a_status_code, clock, reset, rsp_valid, rsp_solve_status != 2'd3)

   // A solved angle always lies on the principal range.
   `RJAFT_ASSERT_IMPLY(a_angle_range, clock, reset, rsp_valid && (rsp_solve_status == rjaft_pkg::ST_SUCCESS), (rsp_joint_angle >= -rjaft_pkg::PI_Q12) && (rsp_joint_angle <= rjaft_pkg::PI_Q12))

   // Reset empties the pipeline.
   `RJAFT_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)

endmodule

bind revolute_joint_angle_from_target rjaft_check u_rjaft_check (.*);

// File: sim/rjaft_checker.sv
// Checker for the joint angle solver: watches both channels, predicts and compares.
`timescale 1ns / 100ps
module rjaft_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic signed [23:0] req_target_x,
   input  logic signed [23:0] req_target_y,
   input  logic signed [23:0] req_target_z,
   input  logic signed [15:0] req_seed_angle,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_joint_angle,
   input  logic [1:0]         rsp_solve_status,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [47:0]        csr_write_data,
   output int                 fail_count,
   output int                 pending_count
);

   typedef struct packed {
      logic signed [15:0]    angle;
      rjaft_pkg::status_type status;
   } solution_type;

   localparam longint PI12 = 12868;

   logic [47:0]  axis_q, refd_q;
   longint       org_q[3];
   longint       lo_q, hi_q, thr_q;
   solution_type solutions_due[$];

   // Arithmetic shift with floor, as in the datapath.
   function automatic longint floor_shift(longint x, int n);
      return x >>> n;
   endfunction

   function automatic longint round_shift(longint x, int n);
      return floor_shift(x + (longint'(1) << (n - 1)), n);
   endfunction

   function automatic longint dir_comp(logic [47:0] v, int k);
      logic signed [15:0] c;
      c = v[16*k +: 16];
      return longint'(c);
   endfunction

   function automatic bit in_limits(longint t);
      return t >= lo_q && t <= hi_q;
   endfunction

   function automatic longint nearer(longint seed, longint a, longint b);
      longint da, db;
      da = a - seed;
      db = b - seed;
      if (da < 0) da = -da;
      if (db < 0) db = -db;
      return (db < da) ? b : a;
   endfunction

   function automatic longint atan2_q12(longint s, longint c);
      longint x, y, z, t, xs, ys, tab[17];
      tab = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
              256, 128, 64, 32, 16, 8, 4, 2, 1};
      if (s == 0) return (c < 0) ? PI12 : 0;
      x = c; y = s; z = 0;
      if (x < 0) begin
         if (y >= 0) begin
            t = x; x = y; y = -t; z = 102944;
         end else begin
            t = x; x = -y; y = t; z = -102944;
         end
      end
      for (int i = 0; i < rjaft_pkg::CORDIC_STAGES; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (y >= 0) begin
            x += ys; y -= xs; z += (i < 17) ? tab[i] : 0;
         end else begin
            x -= ys; y += xs; z -= (i < 17) ? tab[i] : 0;
         end
      end
      t = round_shift(z, 4);
      if (t > PI12) t = PI12;
      if (t < -PI12) t = -PI12;
      return t;
   endfunction

   function automatic solution_type solve_joint(longint tx, longint ty, longint tz,
                                                longint seed);
      longint r[3], a[3], r0[3], q[3], k[3], d, s, c, thr, th1, th2, sel;
      bit v1, v2, sing;
      solution_type sol;
      r[0] = tx - org_q[0];
      r[1] = ty - org_q[1];
      r[2] = tz - org_q[2];
      d = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = dir_comp(axis_q, i);
         r0[i] = dir_comp(refd_q, i);
         d += r[i] * a[i];
      end
      for (int i = 0; i < 3; i++)
         q[i] = round_shift(r[i] * (longint'(1) << 28) - d * a[i], 20);
      thr = thr_q << 8;
      sing = (q[0] < 0 ? -q[0] : q[0]) < thr && (q[1] < 0 ? -q[1] : q[1]) < thr
             && (q[2] < 0 ? -q[2] : q[2]) < thr
             && (q[0] * q[0] + q[1] * q[1] + q[2] * q[2]) < thr * thr;
      sel = seed;
      if (sing) begin
         sol.status = rjaft_pkg::ST_SINGULAR;
      end else begin
         k[0] = round_shift(r0[1] * q[2] - r0[2] * q[1], 14);
         k[1] = round_shift(r0[2] * q[0] - r0[0] * q[2], 14);
         k[2] = round_shift(r0[0] * q[1] - r0[1] * q[0], 14);
         s = round_shift(a[0] * k[0] + a[1] * k[1] + a[2] * k[2], 14);
         c = round_shift(r0[0] * q[0] + r0[1] * q[1] + r0[2] * q[2], 14);
         th1 = atan2_q12(s, c);
         th2 = 0;
         v2 = 0;
         if (th1 == 0 || th1 == PI12 || th1 == -PI12) begin
            if (in_limits(0)) begin
               th2 = 0; v2 = 1;
            end
            if (in_limits(PI12)) begin
               th2 = v2 ? nearer(seed, th2, PI12) : PI12; v2 = 1;
            end
            if (in_limits(-PI12)) begin
               th2 = v2 ? nearer(seed, th2, -PI12) : -PI12; v2 = 1;
            end
         end else begin
            th2 = (th1 > 0) ? th1 - PI12 : th1 + PI12;
            v2 = in_limits(th2);
         end
         v1 = in_limits(th1);
         sol.status = rjaft_pkg::ST_SUCCESS;
         if (v1 && v2) sel = nearer(seed, th1, th2);
         else if (v1) sel = th1;
         else if (v2) sel = th2;
         else sol.status = rjaft_pkg::ST_UNREACHABLE;
      end
      sol.angle = 16'(sel);
      return sol;
   endfunction

   task automatic report_mismatch(string what);
      $display("%0t: %s", $realtime, what);
      fail_count++;
   endtask

   assign pending_count = solutions_due.size();

   always @(posedge clock) begin
      solution_type got, want;
      if (reset) begin
         axis_q <= '0;
         refd_q <= '0;
         org_q <= '{0, 0, 0};
         lo_q <= -PI12;
         hi_q <= PI12;
         thr_q <= 1;
         solutions_due.delete();
      end else begin
         if (csr_write_en) begin
            case (rjaft_pkg::csr_index_type'(csr_index))
               rjaft_pkg::CSR_AXIS:        axis_q <= csr_write_data;
               rjaft_pkg::CSR_REFERENCE:   refd_q <= csr_write_data;
               rjaft_pkg::CSR_ORIGIN_X:
                  org_q[0] <= longint'($signed(csr_write_data[23:0]));
               rjaft_pkg::CSR_ORIGIN_Y:
                  org_q[1] <= longint'($signed(csr_write_data[23:0]));
               rjaft_pkg::CSR_ORIGIN_Z:
                  org_q[2] <= longint'($signed(csr_write_data[23:0]));
               rjaft_pkg::CSR_LOWER_LIMIT:
                  lo_q <= longint'($signed(csr_write_data[15:0]));
               rjaft_pkg::CSR_UPPER_LIMIT:
                  hi_q <= longint'($signed(csr_write_data[15:0]));
               rjaft_pkg::CSR_THRESHOLD:
                  thr_q <= longint'(csr_write_data[15:0]);
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            solutions_due.push_back(solve_joint(req_target_x, req_target_y, req_target_z,
                                                req_seed_angle));
         if (rsp_valid && rsp_ready) begin
            got.angle = rsp_joint_angle;
            got.status = rjaft_pkg::status_type'(rsp_solve_status);
            if (solutions_due.size() == 0) begin
               report_mismatch("response word with nothing expected");
            end else begin
               want = solutions_due.pop_front();
               if (got.angle !== want.angle)
                  report_mismatch($sformatf("joint_angle %0d, expected %0d",
                                            got.angle, want.angle));
               if (got.status !== want.status)
                  report_mismatch($sformatf("solve_status %0d, expected %0d",
                                            got.status, want.status));
            end
         end
      end
   end

   initial fail_count = 0;

endmodule

// File: sim/tb_revolute_joint_angle_from_target.sv
// Stimulus and verdict for the joint angle solver testbench.
`timescale 1ns / 100ps
module tb_revolute_joint_angle_from_target;

   localparam int LATENCY = rjaft_pkg::PIPE_STAGES;
   localparam int CYCLE_LIMIT = 200000;

   logic               clock, reset;
   logic               req_valid, req_ready, rsp_valid, rsp_ready;
   logic signed [23:0] req_target_x, req_target_y, req_target_z;
   logic signed [15:0] req_seed_angle, rsp_joint_angle;
   logic [1:0]         rsp_solve_status;
   logic               csr_write_en;
   logic [2:0]         csr_index;
   logic [47:0]        csr_write_data;
   int                 fail_count, pending_count, cycle_count;
   bit                 quiet_tail, hold_off;

   revolute_joint_angle_from_target i_dut (.*);

   rjaft_checker i_checker (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Receiver: random stall bursts, plus one long hold-off, none near the end.
   initial begin
      int n;
      rsp_ready = 0;
      @(posedge clock iff !reset);
      forever begin
         if (hold_off) begin
            rsp_ready <= 0;
            repeat (200) @(posedge clock);
            hold_off = 0;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 0;
            n = $urandom_range(1, 15);
            repeat (n) @(posedge clock);
         end else begin
            rsp_ready <= 1;
            n = $urandom_range(1, 20);
            repeat (n) @(posedge clock);
         end
      end
   end

   function automatic logic [23:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 24'sh7FFFFF;
         1: return 24'sh800000;
         2: return 24'($urandom_range(0, 64)) - 24'd32;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_angle();
      case ($urandom_range(0, 5))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'(rjaft_pkg::PI_Q12);
         3: return 16'(-rjaft_pkg::PI_Q12);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic write_reg(rjaft_pkg::csr_index_type idx, logic [47:0] value);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 0;
   endtask

   task automatic send_target(logic [23:0] x, logic [23:0] y, logic [23:0] z,
                              logic [15:0] seed);
      int n;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         n = $urandom_range(1, 15);
         repeat (n) @(posedge clock);
      end
      req_valid <= 1;
      req_target_x <= x;
      req_target_y <= y;
      req_target_z <= z;
      req_seed_angle <= seed;
      @(posedge clock iff req_ready);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock iff pending_count == 0);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Packs three Q1.14 components.
   function automatic logic [47:0] dir3(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      return {z, y, x};
   endfunction

   initial begin
      logic [47:0] axes[4], refs[4];
      axes = '{dir3(0, 0, 16384), dir3(16384, 0, 0), dir3(0, 16'hC000, 0),
               dir3(9459, 9459, 9459)};
      refs = '{dir3(16384, 0, 0), dir3(0, 16384, 0), dir3(0, 0, 16384),
               dir3(11585, 16'hD2BF, 0)};
      cycle_count = 0;
      quiet_tail = 0;
      hold_off = 0;
      reset = 1;
      req_valid = 0;
      req_target_x = 0;
      req_target_y = 0;
      req_target_z = 0;
      req_seed_angle = 0;
      csr_write_en = 0;
      csr_index = rjaft_pkg::CSR_AXIS;
      csr_write_data = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Zero direction registers: every target gives a zero sine.
      send_target(24'sh7FFFFF, 24'sh800000, 0, 16'h7FFF);
      send_target(0, 0, 0, 16'h8000);
      drain();

      write_reg(rjaft_pkg::CSR_AXIS, dir3(0, 0, 16384));
      write_reg(rjaft_pkg::CSR_REFERENCE, dir3(16384, 0, 0));
      // Directed words: cardinal points, singular, angle pi and zero, extremes.
      send_target(0, 0, 0, 0);
      send_target(65536, 0, 0, 16'(rjaft_pkg::PI_Q12));
      send_target(-65536, 0, 0, 0);
      send_target(-65536, 0, 0, 16'(-rjaft_pkg::PI_Q12));
      send_target(0, 65536, 0, 0);
      send_target(0, -65536, 0, 16'(-rjaft_pkg::PI_Q12));
      send_target(65536, 65536, 24'sh7FFFFF, 16'h7FFF);
      send_target(-65536, -1, 24'sh800000, 16'h8000);
      send_target(100, 0, 0, 0);
      send_target(24'sh7FFFFF, 24'sh7FFFFF, 0, 0);
      send_target(24'sh800000, 24'sh800000, 0, 0);
      drain();

      // Narrow limits (unreachable) and zero threshold; then widest limits, top threshold.
      write_reg(rjaft_pkg::CSR_LOWER_LIMIT, 16'd100);
      write_reg(rjaft_pkg::CSR_UPPER_LIMIT, 16'd200);
      write_reg(rjaft_pkg::CSR_THRESHOLD, 0);
      send_target(0, 0, 0, 5);
      send_target(-65536, 0, 0, 5);
      send_target(0, 65536, 0, 5);
      send_target(1000, 10, 0, 5);
      drain();
      write_reg(rjaft_pkg::CSR_LOWER_LIMIT, 16'h8000);
      write_reg(rjaft_pkg::CSR_UPPER_LIMIT, 16'h7FFF);
      write_reg(rjaft_pkg::CSR_THRESHOLD, 16'hFFFF);
      write_reg(rjaft_pkg::CSR_ORIGIN_X, 48'h7FFFFF);
      send_target(0, 0, 0, 0);
      send_target(24'sh800000, 0, 0, 0);
      drain();

      // Random phases across register settings.
      for (int ph = 0; ph < 10; ph++) begin
         write_reg(rjaft_pkg::CSR_AXIS, ph == 9 ? 48'($urandom) << 16 | 48'($urandom) :
                   axes[ph % 4]);
         write_reg(rjaft_pkg::CSR_REFERENCE, ph == 8 ? {16'($urandom), 32'($urandom)} :
                   refs[ph % 4]);
         write_reg(rjaft_pkg::CSR_ORIGIN_X,
                   ph < 2 ? 48'(ph == 0 ? 24'h800000 : 24'h7FFFFF)
                   : 48'($urandom_range(0, 20000)));
         write_reg(rjaft_pkg::CSR_ORIGIN_Y, 48'($urandom) & 48'hFFFFFF);
         write_reg(rjaft_pkg::CSR_ORIGIN_Z, 48'($urandom) & 48'hFFFFFF);
         case (ph % 4)
            0: begin
               write_reg(rjaft_pkg::CSR_LOWER_LIMIT, 16'(-rjaft_pkg::PI_Q12));
               write_reg(rjaft_pkg::CSR_UPPER_LIMIT, 16'(rjaft_pkg::PI_Q12));
            end
            1: begin
               write_reg(rjaft_pkg::CSR_LOWER_LIMIT, 16'h8000);
               write_reg(rjaft_pkg::CSR_UPPER_LIMIT, 16'h7FFF);
            end
            2: begin
               write_reg(rjaft_pkg::CSR_LOWER_LIMIT,
                         16'($urandom_range(0, 8000)) - 16'd4000);
               write_reg(rjaft_pkg::CSR_UPPER_LIMIT, 16'($urandom_range(4000, 13000)));
            end
            default: begin
               write_reg(rjaft_pkg::CSR_LOWER_LIMIT, 16'd3000);
               write_reg(rjaft_pkg::CSR_UPPER_LIMIT, 16'hF000);
            end
         endcase
         write_reg(rjaft_pkg::CSR_THRESHOLD,
                   ph == 3 ? 16'hFFFF : 16'($urandom_range(0, 300)));
         if (ph == 2) hold_off = 1;
         if (ph == 9) quiet_tail = 1;
         for (int i = 0; i < 82; i++)
            send_target(pick_coord(), pick_coord(), pick_coord(), pick_angle());
         drain();
      end

      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
